// ===== sv/assert_macros.svh =====
// Assertion helper macros for the RTL of the distinct value counter.
// No dependencies; included by each module that carries assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising clock edge while reset is released.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checked at every rising clock edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== sv/dvc_pkg.sv =====
// Package for the distinct value counter: sizes, types and state codes.
// No dependencies; used by dvc_front, dvc_back and distinct_value_counter.
`timescale 1ns / 1ps
`default_nettype none

package dvc_pkg;

    // Default table geometry.
    localparam int TABLE_DEPTH_DEF = 64;
    localparam int COUNT_WIDTH_DEF = 16;

    // Fixed field widths of the stream items.
    localparam int SAMPLE_W    = 32;
    localparam int OUT_COUNT_W = 16;
    localparam int CNT_EXT_W   = 32;
    localparam logic [CNT_EXT_W-1:0] OUT_COUNT_MAX = CNT_EXT_W'(65535);

    // Depth of the queue between front and back; a power of two.
    localparam int QUEUE_DEPTH = 2;

    // One queued request.
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample_value;
    } dvc_item_t;

    // One result as it leaves the back end.
    typedef struct packed {
        logic                   was_dropped;
        logic                   is_new_entry;
        logic [OUT_COUNT_W-1:0] occurrence_count;
    } dvc_result_t;

    // Back end sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_CHECK,
        ST_FINISH
    } dvc_state_t;

endpackage

`default_nettype wire

// ===== sv/dvc_front.sv =====
// Front end of the distinct value counter: accepts requests into a short queue.
// Depends on dvc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dvc_front (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         s_tvalid,
    output logic                              s_tready,
    input  wire logic [dvc_pkg::SAMPLE_W-1:0] s_tdata,
    input  wire logic                         q_pop,
    output logic                              q_valid,
    output dvc_pkg::dvc_item_t                q_item
);

    localparam int QPTR_W = (dvc_pkg::QUEUE_DEPTH > 1) ? $clog2(dvc_pkg::QUEUE_DEPTH) : 1;
    localparam int QCNT_W = $clog2(dvc_pkg::QUEUE_DEPTH + 1);

    dvc_pkg::dvc_item_t q_mem [dvc_pkg::QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]  fill_reg, fill_next;
    logic               push;
    logic               pop;

    // Handshake flags of the queue.
    assign s_tready = (fill_reg != QCNT_W'(dvc_pkg::QUEUE_DEPTH));
    assign q_valid  = (fill_reg != '0);
    assign push     = s_tvalid && s_tready;
    assign pop      = q_pop && q_valid;
    assign q_item   = q_mem[rd_ptr_reg];

    // Pointer and fill level updates.
    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        fill_next   = fill_reg;
        if (push && !pop) begin
            fill_next = fill_reg + QCNT_W'(1);
        end else if (pop && !push) begin
            fill_next = fill_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // Queue storage.
    always_ff @(posedge aclk) begin
        if (push) begin
            q_mem[wr_ptr_reg].sample_value <= s_tdata;
        end
    end

endmodule

`default_nettype wire

// ===== sv/dvc_back.sv =====
// Back end of the distinct value counter: table search, update and result register.
// Depends on dvc_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module dvc_back #(
    parameter int TABLE_DEPTH = dvc_pkg::TABLE_DEPTH_DEF,
    parameter int COUNT_WIDTH = dvc_pkg::COUNT_WIDTH_DEF
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                q_valid,
    input  wire dvc_pkg::dvc_item_t  q_item,
    output logic                     q_pop,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output dvc_pkg::dvc_result_t     m_result
);

    localparam int IDX_W  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int USED_W = $clog2(TABLE_DEPTH + 1);
    localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};

    // Table memories.
    logic [dvc_pkg::SAMPLE_W-1:0] val_mem [TABLE_DEPTH];
    logic [COUNT_WIDTH-1:0]       cnt_mem [TABLE_DEPTH];

    dvc_pkg::dvc_state_t          state_reg, state_next;
    logic [USED_W-1:0]            used_reg, used_next;
    logic [IDX_W-1:0]             idx_reg, idx_next;
    logic [dvc_pkg::SAMPLE_W-1:0] val_reg, val_next;
    logic [dvc_pkg::SAMPLE_W-1:0] rd_val_reg;
    logic [COUNT_WIDTH-1:0]       rd_cnt_reg;
    logic                         out_valid_reg, out_valid_next;
    dvc_pkg::dvc_result_t         out_reg, out_next;

    logic                         out_free;
    logic                         hit;
    logic                         last;
    logic                         full;
    logic [COUNT_WIDTH-1:0]       new_cnt;
    logic [dvc_pkg::CNT_EXT_W-1:0] cnt_ext;
    logic [dvc_pkg::OUT_COUNT_W-1:0] sat_out;
    logic                         val_we;
    logic                         cnt_we;
    logic [IDX_W-1:0]             wr_addr;
    logic [COUNT_WIDTH-1:0]       wr_cnt;

    // Status of the current search.
    assign out_free = !out_valid_reg || m_ready;
    assign hit      = (rd_val_reg == val_reg);
    assign last     = ((USED_W'(idx_reg) + USED_W'(1)) == used_reg);
    assign full     = (used_reg == USED_W'(TABLE_DEPTH));

    // Saturating count increment and clamp to the output field.
    assign new_cnt = (rd_cnt_reg == CNT_MAX) ? rd_cnt_reg : rd_cnt_reg + COUNT_WIDTH'(1);
    assign cnt_ext = dvc_pkg::CNT_EXT_W'(new_cnt);
    assign sat_out = (cnt_ext > dvc_pkg::OUT_COUNT_MAX) ?
                     dvc_pkg::OUT_COUNT_MAX[dvc_pkg::OUT_COUNT_W-1:0] :
                     cnt_ext[dvc_pkg::OUT_COUNT_W-1:0];

    // Next state of the sequencer.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            dvc_pkg::ST_IDLE: begin
                if (q_valid && out_free) begin
                    state_next = (used_reg == '0) ? dvc_pkg::ST_FINISH : dvc_pkg::ST_READ;
                end
            end
            dvc_pkg::ST_READ: begin
                state_next = dvc_pkg::ST_CHECK;
            end
            dvc_pkg::ST_CHECK: begin
                if (hit) begin
                    state_next = dvc_pkg::ST_IDLE;
                end else if (last) begin
                    state_next = dvc_pkg::ST_FINISH;
                end else begin
                    state_next = dvc_pkg::ST_READ;
                end
            end
            dvc_pkg::ST_FINISH: begin
                state_next = dvc_pkg::ST_IDLE;
            end
            default: begin
                state_next = dvc_pkg::ST_IDLE;
            end
        endcase
    end

    // Datapath controls of the sequencer.
    always_comb begin
        q_pop          = 1'b0;
        val_we         = 1'b0;
        cnt_we         = 1'b0;
        wr_addr        = idx_reg;
        wr_cnt         = new_cnt;
        idx_next       = idx_reg;
        val_next       = val_reg;
        used_next      = used_reg;
        out_valid_next = out_valid_reg && !m_ready;
        out_next       = out_reg;
        case (state_reg)
            dvc_pkg::ST_IDLE: begin
                if (q_valid && out_free) begin
                    q_pop    = 1'b1;
                    val_next = q_item.sample_value;
                    idx_next = '0;
                end
            end
            dvc_pkg::ST_READ: begin
            end
            dvc_pkg::ST_CHECK: begin
                if (hit) begin
                    cnt_we         = 1'b1;
                    out_valid_next = 1'b1;
                    out_next.occurrence_count = sat_out;
                    out_next.is_new_entry     = 1'b0;
                    out_next.was_dropped      = 1'b0;
                end else if (!last) begin
                    idx_next = idx_reg + IDX_W'(1);
                end
            end
            dvc_pkg::ST_FINISH: begin
                out_valid_next = 1'b1;
                if (!full) begin
                    val_we    = 1'b1;
                    cnt_we    = 1'b1;
                    wr_addr   = used_reg[IDX_W-1:0];
                    wr_cnt    = COUNT_WIDTH'(1);
                    used_next = used_reg + USED_W'(1);
                    out_next.occurrence_count = dvc_pkg::OUT_COUNT_W'(1);
                    out_next.is_new_entry     = 1'b1;
                    out_next.was_dropped      = 1'b0;
                end else begin
                    out_next.occurrence_count = '0;
                    out_next.is_new_entry     = 1'b0;
                    out_next.was_dropped      = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= dvc_pkg::ST_IDLE;
            used_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            used_reg      <= used_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        idx_reg <= idx_next;
        val_reg <= val_next;
        out_reg <= out_next;
    end

    // Table memories with registered read at the search index.
    always_ff @(posedge aclk) begin
        if (val_we) begin
            val_mem[wr_addr] <= val_reg;
        end
        if (cnt_we) begin
            cnt_mem[wr_addr] <= wr_cnt;
        end
        rd_val_reg <= val_mem[idx_reg];
        rd_cnt_reg <= cnt_mem[idx_reg];
    end

    assign m_valid  = out_valid_reg;
    assign m_result = out_reg;

    // Checks on the sequencer and the result register.
    `ASSERT_CLK(a_used_bound, aclk, aresetn, used_reg <= USED_W'(TABLE_DEPTH), "table fill exceeds depth")
    `ASSERT_CLK(a_check_after_read, aclk, aresetn, (state_reg == dvc_pkg::ST_CHECK) |-> ($past(state_reg) == dvc_pkg::ST_READ), "compare without a table read")
    `ASSERT_CLK(a_finish_result, aclk, aresetn, (state_reg == dvc_pkg::ST_FINISH) |=> out_valid_reg, "finished search left no result")
    `ASSERT_CLK(a_drop_fields, aclk, aresetn, (out_valid_reg && out_reg.was_dropped) |-> ((out_reg.occurrence_count == '0) && !out_reg.is_new_entry), "dropped result carries a count")

endmodule

`default_nettype wire

// ===== sv/distinct_value_counter.sv =====
// Distinct value counter: counts occurrences of each distinct 32-bit sample value.
// Instantiates dvc_front and dvc_back; depends on dvc_pkg.
//
// Usage:
// - Input channel s_*: one signed 32-bit sample per request in s_tdata.
// - Result channel m_*: one result per request, in request order, in m_tdata.
// - Requests enter a two-deep queue, so s_tready stays high while the table
//   search of an earlier request is under way, until the queue is full.
// - The search walks the table one entry at a time through the single
//   read port of the table memory, a read state and then a compare state
//   per entry: a value found at slot k gives its result once slots 0..k
//   are compared; a new or dropped value is compared with all N slots in
//   use, N being the number of slots in use, and then passes a finish state.
//   The back end takes the next request only once that search is over.
// - Reset empties the table and the queue at once; the table contents need
//   no clearing since only slots below the fill count are ever read.
// - When m_tready is low the result waits in the output register; the
//   queue keeps accepting until it is full, then s_tready drops.
`timescale 1ns / 1ps
`default_nettype none

module distinct_value_counter #(
    parameter int TABLE_DEPTH = dvc_pkg::TABLE_DEPTH_DEF,
    parameter int COUNT_WIDTH = dvc_pkg::COUNT_WIDTH_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // [31:0] sample_value
    input  wire logic [31:0] s_tdata,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // [15:0] occurrence_count, [16] is_new_entry, [17] was_dropped, [23:18] zero
    output logic [23:0]      m_tdata
);

    logic                 q_valid;
    logic                 q_pop;
    dvc_pkg::dvc_item_t   q_item;
    dvc_pkg::dvc_result_t result;

    // Request queue.
    dvc_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .q_pop    (q_pop),
        .q_valid  (q_valid),
        .q_item   (q_item)
    );

    // Table search and update.
    dvc_back #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_pop    (q_pop),
        .m_valid  (m_tvalid),
        .m_ready  (m_tready),
        .m_result (result)
    );

    // Pack the result fields, padded to whole bytes.
    assign m_tdata = {6'b0, result.was_dropped, result.is_new_entry, result.occurrence_count};

endmodule

`default_nettype wire

// ===== verif/dvc_checker.sv =====
`timescale 1ns / 1ps
// Checker for the distinct value counter: watches both stream channels, predicts each result
// from its own copy of the value table and compares. Depends on dvc_pkg.

module dvc_checker #(
    parameter int TABLE_DEPTH = dvc_pkg::TABLE_DEPTH_DEF,
    parameter int COUNT_WIDTH = dvc_pkg::COUNT_WIDTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    // [31:0] sample_value
    input  logic [31:0] s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    // [15:0] occurrence_count, [16] is_new_entry, [17] was_dropped, [23:18] zero
    input  logic [23:0] m_tdata,
    output int          error_count,
    output int          pending,
    output int          new_count,
    output int          hit_count,
    output int          drop_count,
    output int          ceiling_count
);

    localparam longint unsigned COUNT_CEILING = (64'd1 << COUNT_WIDTH) - 1;
    localparam longint unsigned REPORT_CEILING = 65535;

    // Shadow copy of the value table.
    logic [dvc_pkg::SAMPLE_W-1:0] known_values [TABLE_DEPTH];
    longint unsigned              known_counts [TABLE_DEPTH];
    int                           known_used;

    // Results still owed by the block, oldest first.
    dvc_pkg::dvc_result_t owed_results[$];

    // Update the shadow table with one sample and return the result it should give.
    function automatic dvc_pkg::dvc_result_t tally_sample(logic [dvc_pkg::SAMPLE_W-1:0] value);
        dvc_pkg::dvc_result_t res;
        longint unsigned      cnt;
        res = '0;
        for (int slot = 0; slot < known_used; slot++) begin
            if (known_values[slot] == value) begin
                cnt = known_counts[slot];
                if (cnt < COUNT_CEILING) begin
                    cnt++;
                end
                known_counts[slot] = cnt;
                res.occurrence_count = (cnt > REPORT_CEILING) ?
                                       dvc_pkg::OUT_COUNT_W'(REPORT_CEILING) :
                                       dvc_pkg::OUT_COUNT_W'(cnt);
                hit_count++;
                if (cnt == COUNT_CEILING || cnt >= REPORT_CEILING) begin
                    ceiling_count++;
                end
                return res;
            end
        end
        if (known_used < TABLE_DEPTH) begin
            known_values[known_used] = value;
            known_counts[known_used] = 1;
            known_used++;
            res.occurrence_count = dvc_pkg::OUT_COUNT_W'(1);
            res.is_new_entry     = 1'b1;
            new_count++;
        end else begin
            // Table full: the value is refused and the table stays as it is.
            res.was_dropped = 1'b1;
            drop_count++;
        end
        return res;
    endfunction

    // Compare results on their way out, then record what each new request owes.
    always @(posedge aclk) begin
        dvc_pkg::dvc_result_t got;
        dvc_pkg::dvc_result_t want;
        if (!aresetn) begin
            known_used    = 0;
            owed_results.delete();
            error_count   = 0;
            new_count     = 0;
            hit_count     = 0;
            drop_count    = 0;
            ceiling_count = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                got = dvc_pkg::dvc_result_t'(m_tdata[17:0]);
                if (m_tdata[23:18] != '0) begin
                    $error("padding: expected 0, actual %0h", m_tdata[23:18]);
                    error_count++;
                end
                if (owed_results.size() == 0) begin
                    $error("result %0h arrived with no request outstanding", m_tdata);
                    error_count++;
                end else begin
                    want = owed_results.pop_front();
                    if (got.occurrence_count != want.occurrence_count) begin
                        $error("occurrence_count: expected %0d, actual %0d",
                               want.occurrence_count, got.occurrence_count);
                        error_count++;
                    end
                    if (got.is_new_entry != want.is_new_entry) begin
                        $error("is_new_entry: expected %0d, actual %0d",
                               want.is_new_entry, got.is_new_entry);
                        error_count++;
                    end
                    if (got.was_dropped != want.was_dropped) begin
                        $error("was_dropped: expected %0d, actual %0d",
                               want.was_dropped, got.was_dropped);
                        error_count++;
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                owed_results.push_back(tally_sample(s_tdata));
            end
        end
        pending <= owed_results.size();
    end

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// Testbench top for the distinct value counter: drives sample requests, idles the result side
// at random and gives the verdict. Depends on dvc_pkg, dvc_checker and the counter RTL.

module tb_top;

    localparam int TABLE_DEPTH   = dvc_pkg::TABLE_DEPTH_DEF;
    localparam int COUNT_WIDTH   = dvc_pkg::COUNT_WIDTH_DEF;
    localparam int QUIET_LIMIT   = 4000;
    localparam int SETTLE_CYCLES = 2 * TABLE_DEPTH + 100;
    localparam int RANDOM_ITEMS  = 1500;
    localparam int REPEAT_ITEMS  = 100;
    localparam int POOL_SIZE     = 96;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;

    int error_count;
    int pending;
    int new_count;
    int hit_count;
    int drop_count;
    int ceiling_count;

    bit idle_off = 1'b0;
    int rx_wait  = 0;
    int quiet    = 0;

    always #6 aclk = ~aclk;

    distinct_value_counter #(
        .TABLE_DEPTH(TABLE_DEPTH),
        .COUNT_WIDTH(COUNT_WIDTH)
    ) u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    dvc_checker #(
        .TABLE_DEPTH(TABLE_DEPTH),
        .COUNT_WIDTH(COUNT_WIDTH)
    ) u_checker (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .error_count  (error_count),
        .pending      (pending),
        .new_count    (new_count),
        .hit_count    (hit_count),
        .drop_count   (drop_count),
        .ceiling_count(ceiling_count)
    );

    // Result side: hold off each result for a random number of cycles once it is offered.
    always @(posedge aclk) begin
        int hold;
        if (!aresetn) begin
            m_tready <= 1'b0;
            rx_wait  <= 0;
        end else if (m_tvalid && m_tready) begin
            hold = idle_off ? 0 : $urandom_range(0, 9);
            rx_wait  <= hold;
            m_tready <= (hold == 0);
        end else if (m_tvalid && rx_wait > 1) begin
            rx_wait <= rx_wait - 1;
        end else if (m_tvalid || rx_wait == 0) begin
            rx_wait  <= 0;
            m_tready <= 1'b1;
        end
    end

    // Watchdog: give up when neither channel moves for too long.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet <= 0;
        end else if (quiet >= QUIET_LIMIT) begin
            $display("Timeout: no request or result moved for %0d cycles", QUIET_LIMIT);
            $display("DONE: errors detected");
            $finish;
        end else begin
            quiet <= quiet + 1;
        end
    end

    // Offer one sample after a random gap and hold it until it is taken.
    task automatic send_sample(input logic [31:0] value);
        int gap;
        gap = idle_off ? 0 : $urandom_range(0, 9);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        do @(posedge aclk); while (!s_tready);
    endtask

    // Stop offering and wait until every owed result has come back.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending != 0);
    endtask

    initial begin
        logic [31:0] pool [POOL_SIZE];
        logic [31:0] corner [12];

        foreach (pool[k]) begin
            pool[k] = $urandom;
        end
        corner = '{32'h0000_0000, 32'h0000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
                   32'hFFFF_FFFF, 32'h8000_0000, 32'h5555_5555, 32'hAAAA_AAAA,
                   32'h7FFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFF, 32'h5555_5555};

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // Extreme and alternating bit patterns, most seen first as new and then as a repeat.
        foreach (corner[k]) begin
            send_sample(corner[k]);
        end
        drain_results();

        // Back-to-back repeats of zero keep raising its count.
        idle_off = 1'b1;
        repeat (REPEAT_ITEMS) send_sample(32'h0000_0000);
        idle_off = 1'b0;
        drain_results();

        // Mostly a fixed pool larger than the table, so it fills, then refuses newcomers
        // while pool members already stored keep counting; the rest is fresh noise.
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 200 == 150) begin
                idle_off = 1'b1;
            end else if (n % 200 == 0) begin
                idle_off = 1'b0;
            end
            if ($urandom_range(0, 9) < 6) begin
                send_sample(pool[$urandom_range(0, POOL_SIZE - 1)]);
            end else begin
                send_sample($urandom);
            end
        end
        idle_off = 1'b0;
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge aclk);

        $display("Covered %0d new entries, %0d repeats (%0d at the count ceiling)",
                 new_count, hit_count, ceiling_count);
        $display("and %0d samples refused by a full table; %0d results still owed.",
                 drop_count, pending);
        if (error_count == 0 && pending == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
